[rtl/utf8d_pkg.sv]
// utf8d_pkg: types, constants and byte classification functions
// for the utf8 stream decoder; no dependencies
package utf8d_pkg;

	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [7:0] CONT_MAX  = 8'hBF;
	localparam logic [7:0] CONT_MIN  = 8'h80;
	localparam logic [7:0] LEAD_E0   = 8'hE0;
	localparam logic [7:0] E0_MIN    = 8'hA0;
	localparam logic [7:0] LEAD_ED   = 8'hED;
	localparam logic [7:0] ED_MAX    = 8'h9F;
	localparam logic [7:0] LEAD_F0   = 8'hF0;
	localparam logic [7:0] F0_MIN    = 8'h90;
	localparam logic [7:0] LEAD_F4   = 8'hF4;
	localparam logic [7:0] F4_MAX    = 8'h8F;
	localparam logic [7:0] LEAD_MIN2 = 8'hC2;
	localparam logic [7:0] LEAD_MIN3 = 8'hE0;
	localparam logic [7:0] LEAD_MIN4 = 8'hF0;
	localparam logic [7:0] LEAD_LIM  = 8'hF8;
	localparam logic [7:0] BOM_B0    = 8'hEF;
	localparam logic [7:0] BOM_B1    = 8'hBB;
	localparam logic [7:0] BOM_B2    = 8'hBF;

	localparam logic [20:0] CP_REPLACE = 21'h00FFFD;
	localparam logic [20:0] CP_MAX     = 21'h10FFFF;
	localparam logic [20:0] SURR_LO    = 21'h00D800;
	localparam logic [20:0] SURR_HI    = 21'h00DFFF;

	localparam logic STATUS_CHAR = 1'b0;
	localparam logic STATUS_ERR  = 1'b1;

	// one completed sequence handed from front to back
	typedef struct packed {
		logic       err;
		logic [1:0] len_m1;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] b3;
	} qent_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	// total sequence length, 0 for a lead in 80..C1 or F8..FF
	function automatic logic [2:0] seq_len(input logic [7:0] lead);
		logic [2:0] n;
		if (lead < CONT_MIN)       n = 3'd1;
		else if (lead < LEAD_MIN2) n = 3'd0;
		else if (lead < LEAD_MIN3) n = 3'd2;
		else if (lead < LEAD_MIN4) n = 3'd3;
		else if (lead < LEAD_LIM)  n = 3'd4;
		else                       n = 3'd0;
		return n;
	endfunction

	function automatic logic is_cont(input logic [7:0] b);
		return (b >= CONT_MIN) && (b <= CONT_MAX);
	endfunction

	function automatic logic seq_legal(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2, input logic [7:0] b3, input logic [2:0] n);
		logic ok;
		ok = 1'b1;
		if (n == 3'd4 && !is_cont(b3)) ok = 1'b0;
		if (n >= 3'd3 && !is_cont(b2)) ok = 1'b0;
		if (n >= 3'd2) begin
			if (b1 > CONT_MAX) ok = 1'b0;
			priority if (b0 == LEAD_E0) begin
				if (b1 < E0_MIN) ok = 1'b0;
			end else if (b0 == LEAD_ED) begin
				if (b1 > ED_MAX) ok = 1'b0;
			end else if (b0 == LEAD_F0) begin
				if (b1 < F0_MIN) ok = 1'b0;
			end else if (b0 == LEAD_F4) begin
				if (b1 > F4_MAX) ok = 1'b0;
			end else begin
				if (b1 < CONT_MIN) ok = 1'b0;
			end
		end
		if (b0 >= CONT_MIN && b0 < LEAD_MIN2) ok = 1'b0;
		if (b0 > LEAD_F4) ok = 1'b0;
		return ok;
	endfunction

endpackage

[rtl/utf8d_front.sv]
// utf8d_front: accepts bytes, buffers unfinished sequences, checks
// them and queues those, bar a leading BOM; depends on utf8d_pkg
module utf8d_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              data_valid,
	output logic              data_stall,
	input  logic [7:0]        data_byte,
	input  utf8d_pkg::qstat_t qstat,
	output logic              push,
	output utf8d_pkg::qent_t  push_ent
);
	import utf8d_pkg::*;

	logic [7:0] pend_q [3];
	logic [1:0] cnt_q;
	logic       start_q;
	logic       err_q;

	logic       accept;
	logic [7:0] lead;
	logic [2:0] need;
	logic [2:0] have;
	logic [7:0] s0, s1, s2;
	logic       legal;
	logic       is_bom;
	logic       complete;

	assign data_stall = qstat.full;
	assign accept     = data_valid && !qstat.full;

	assign lead = (cnt_q == 2'd0) ? data_byte : pend_q[0];
	assign need = seq_len(lead);
	assign have = {1'b0, cnt_q} + 3'd1;
	assign s0   = (cnt_q == 2'd0) ? data_byte : pend_q[0];
	assign s1   = (cnt_q == 2'd1) ? data_byte : pend_q[1];
	assign s2   = (cnt_q == 2'd2) ? data_byte : pend_q[2];
	assign complete = (have >= need);
	assign legal    = seq_legal(s0, s1, s2, data_byte, have);
	assign is_bom   = start_q && have == 3'd3 && s0 == BOM_B0 && s1 == BOM_B1
		&& s2 == BOM_B2;

	always_comb begin
		push            = 1'b0;
		push_ent.err    = 1'b0;
		push_ent.len_m1 = cnt_q;
		push_ent.b0     = s0;
		push_ent.b1     = s1;
		push_ent.b2     = s2;
		push_ent.b3     = data_byte;
		if (accept) begin
			priority if (err_q || (cnt_q == 2'd0 && need == 3'd0)) begin
				push         = 1'b1;
				push_ent.err = 1'b1;
			end else if (complete) begin
				push         = !legal || !is_bom;
				push_ent.err = !legal;
			end else begin
				push = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= 2'd0;
			start_q <= 1'b1;
			err_q   <= 1'b0;
		end else if (accept) begin
			priority if (err_q || (cnt_q == 2'd0 && need == 3'd0)) begin
				err_q   <= 1'b1;
				start_q <= 1'b0;
				cnt_q   <= 2'd0;
			end else if (complete) begin
				cnt_q   <= 2'd0;
				start_q <= 1'b0;
				if (!legal) err_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

	// buffered bytes need no reset, only entries below the count are read
	always_ff @(posedge clk) begin
		if (accept && !err_q && !complete && cnt_q != 2'd3)
			pend_q[cnt_q] <= data_byte;
	end

endmodule

[rtl/utf8d_queue.sv]
// utf8d_queue: short fifo of completed sequences between front and back
// depends on utf8d_pkg
module utf8d_queue #(
	parameter int DEPTH = utf8d_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  utf8d_pkg::qent_t  push_ent,
	input  logic              pop,
	output utf8d_pkg::qent_t  head,
	output utf8d_pkg::qstat_t qstat
);
	import utf8d_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	qent_t         ent_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign qstat.full  = (cnt_q == CW'(DEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign head        = ent_q[rd_q];

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= bump(wr_q);
			if (do_pop)  rd_q <= bump(rd_q);
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) ent_q[wr_q] <= push_ent;
	end

endmodule

[rtl/utf8d_back.sv]
// utf8d_back: assembles the code point of a queued sequence and holds it
// in the output register; depends on utf8d_pkg
module utf8d_back (
	input  logic              clk,
	input  logic              arst_n,
	input  utf8d_pkg::qent_t  head,
	input  utf8d_pkg::qstat_t qstat,
	output logic              pop,
	output logic              result_valid,
	input  logic              result_stall,
	output logic [20:0]       code_point,
	output logic              status
);
	import utf8d_pkg::*;

	logic        valid_q;
	logic [20:0] cp_q;
	logic        st_q;
	logic [20:0] raw;
	logic [20:0] cp;

	assign pop = !qstat.empty && (!valid_q || !result_stall);

	always_comb begin
		unique case (head.len_m1)
			2'd0: raw = {14'd0, head.b0[6:0]};
			2'd1: raw = {10'd0, head.b0[4:0], head.b1[5:0]};
			2'd2: raw = {5'd0, head.b0[3:0], head.b1[5:0], head.b2[5:0]};
			2'd3: raw = {head.b0[2:0], head.b1[5:0], head.b2[5:0], head.b3[5:0]};
			default: raw = '0;
		endcase
		if (head.err)
			cp = '0;
		else if (raw > CP_MAX || (raw >= SURR_LO && raw <= SURR_HI))
			cp = CP_REPLACE;
		else
			cp = raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cp_q <= cp;
			st_q <= head.err ? STATUS_ERR : STATUS_CHAR;
		end
	end

	assign result_valid = valid_q;
	assign code_point   = cp_q;
	assign status       = st_q;

endmodule

[rtl/utf8_stream_decoder.sv]
// utf8_stream_decoder: top level, front classifier, sequence queue and
// code point back end; depends on utf8d_pkg, utf8d_front, utf8d_queue, utf8d_back
//
// channel  | valid        | stall        | payload
// input    | data_valid   | data_stall   | data_byte[7:0]
// result   | result_valid | result_stall | code_point[20:0], status
//
// one byte accepted per cycle while data_stall is low; the queue is written at the edge
// that accepts the last byte and drained into the output register, at most one per byte
// data_stall rises only when the queue is full; the back drains it into the
// output register whenever that register is empty or being taken
// asynchronous reset clears counts and the sticky error and sets the stream start flag
module utf8_stream_decoder #(
	parameter int QUEUE_DEPTH = utf8d_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        data_valid,
	output logic        data_stall,
	input  logic [7:0]  data_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [20:0] code_point,
	output logic        status
);
	import utf8d_pkg::*;

	qstat_t qstat;
	qent_t  push_ent;
	qent_t  head;
	logic   push;
	logic   pop;

	utf8d_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_valid (data_valid),
		.data_stall (data_stall),
		.data_byte  (data_byte),
		.qstat      (qstat),
		.push       (push),
		.push_ent   (push_ent)
	);

	utf8d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_ent (push_ent),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	utf8d_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.qstat        (qstat),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.code_point   (code_point),
		.status       (status)
	);

endmodule

[rtl/utf8d_checker.sv]
// utf8d_checker: port level assertions for utf8_stream_decoder, bound to it
// depends on utf8d_pkg and the top level's ports
module utf8d_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        data_valid,
	input logic        data_stall,
	input logic [7:0]  data_byte,
	input logic        result_valid,
	input logic        result_stall,
	input logic [20:0] code_point,
	input logic        status
);
	import utf8d_pkg::*;

	logic seen_err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_err_q <= 1'b0;
		end else if (result_valid && !result_stall && status == STATUS_ERR) begin
			seen_err_q <= 1'b1;
		end
	end

	// a stalled input word holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		data_valid && data_stall |=> data_valid && $stable(data_byte))
		else $error("stalled input word changed");

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(code_point)
			&& $stable(status))
		else $error("stalled result word changed");

	// error is sticky once delivered
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && seen_err_q |-> status == STATUS_ERR)
		else $error("character result after a delivered error");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == STATUS_ERR |-> code_point == 21'd0)
		else $error("error result with nonzero code point");

	a_scalar: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == STATUS_CHAR |-> code_point <= CP_MAX
			&& (code_point < SURR_LO || code_point > SURR_HI))
		else $error("character result is not a scalar value");

endmodule

bind utf8_stream_decoder utf8d_checker u_chk (.*);
